### rtl/cesm_pkg.sv
// Package for the capacity-bounded store with smallest-first eviction.
// Holds item and entry types, field widths, codes and reset constants.
// No dependencies; every other file of the block but cesm_ram imports it.
package cesm_pkg;

   // Field widths of the items
   localparam int ID_W          = 8;
   localparam int TS_W          = 32;
   localparam int SIZE_W        = 16;
   localparam int TOTAL_OUT_W   = 20;
   localparam int ENTRY_CNT_W   = 5;

   // Default number of entries held
   localparam int CAPACITY_DEF  = 16;

   // At most this many evictions per optimize item
   localparam int MAX_BURST     = 16;
   localparam int BURST_W       = $clog2(MAX_BURST + 1);

   // Reported total saturates here
   localparam logic [TOTAL_OUT_W-1:0] TOTAL_OUT_MAX = {TOTAL_OUT_W{1'b1}};

   // Reset value of the size ceiling: 32 GB in 1/1024 GB units
   localparam logic [TOTAL_OUT_W-1:0] LIMIT_RESET = TOTAL_OUT_W'(32768);

   // Operation codes
   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_OPTIMIZE = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [ID_W-1:0]   file_id;
      logic [TS_W-1:0]   timestamp;
      logic [SIZE_W-1:0] size;
   } req_item_type;

   typedef struct packed {
      logic                   evicted_valid;
      logic [ID_W-1:0]        evicted_id;
      logic [TS_W-1:0]        evicted_timestamp;
      logic [SIZE_W-1:0]      evicted_size;
      logic [TOTAL_OUT_W-1:0] total_size;
      logic [ENTRY_CNT_W-1:0] entry_count;
      logic                   full_error;
      logic                   last;
   } rsp_item_type;

   // One stored entry, as kept in the entry memory
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TS_W-1:0]   timestamp;
      logic [SIZE_W-1:0] size;
   } entry_type;

endpackage

### rtl/capacity_evict_smallest_store_top.sv
// Top level of the capacity-bounded store with smallest-first eviction.
// Depends on cesm_pkg, cesm_engine (with cesm_ram) and cesm_out_reg.
//
// Holds up to CAPACITY entries (id, timestamp, size) in timestamp order in one
// synchronous entry memory. The engine works on one item at a time; req_ready
// is high only while it is idle, and it drops again until the item's last
// result has been handed to the output register. An insert walks down from
// the tail, shifting each entry that is not older up one place with one read
// and one write on the memory's single read and write port, then places the
// item; a dropped insert on a full store goes straight to its result with
// full_error set. An optimize item, per eviction, scans all held entries for
// the smallest, compacts by reading and writing each entry behind the evicted
// one, then accounts and emits the result, at most 16 evictions per item; an
// optimize within the ceiling emits its result without a scan. Results leave
// through an output register, so a stalled consumer holds the engine only
// when a second result is ready. size_limit is written on the csr port
// (always ready); the user writes it only between items, which the block
// does not enforce. Sizes are in 1/1024 GB, and total_size saturates at the
// top of its 20-bit range.
module capacity_evict_smallest_store_top #(
   parameter int CAPACITY = cesm_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  cesm_pkg::req_item_type           req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cesm_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cesm_pkg::TOTAL_OUT_W-1:0] csr_data
);
   import cesm_pkg::*;

   logic         res_valid;
   logic         res_ready;
   rsp_item_type res_item;

   // Store engine with its entry memory
   cesm_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_item  (res_item)
   );

   // Register the results toward the consumer
   cesm_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_item   (res_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/cesm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cesm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cesm_out_reg.sv
// Output register of the result channel: parts the engine from the consumer.
// Depends on cesm_pkg for the result item type.
module cesm_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cesm_pkg::rsp_item_type in_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cesm_pkg::rsp_item_type rsp_item
);
   import cesm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // Take a new item when the slot is empty or being drained
   assign in_ready = !valid_ff || rsp_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until a new item is loaded
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

### rtl/cesm_engine.sv
// Store engine: ordered entry memory, insert shifting, smallest-entry scan and
// compaction, running total, count and size ceiling. Depends on cesm_pkg, cesm_ram.
module cesm_engine #(
   parameter int CAPACITY = cesm_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cesm_pkg::req_item_type              req_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cesm_pkg::TOTAL_OUT_W-1:0]    csr_data,
   output logic                                res_valid,
   input  logic                                res_ready,
   output cesm_pkg::rsp_item_type              res_item
);
   import cesm_pkg::*;

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int TOT_W   = $clog2(CAPACITY * (2 ** SIZE_W));
   localparam int EXT_W   = TOT_W + TOTAL_OUT_W;
   localparam int CEXT_W  = CNT_W + ENTRY_CNT_W;
   localparam int ENTRY_W = $bits(entry_type);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_INS_RD    = 3'd1;
   localparam logic [2:0] ST_INS_WR    = 3'd2;
   localparam logic [2:0] ST_OPT_START = 3'd3;
   localparam logic [2:0] ST_SCAN      = 3'd4;
   localparam logic [2:0] ST_SH_RD     = 3'd5;
   localparam logic [2:0] ST_SH_WR     = 3'd6;
   localparam logic [2:0] ST_EMIT      = 3'd7;

   // Control state
   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       held_count_ff, held_count_in;
   logic [TOT_W-1:0]       total_ff, total_in;
   logic [TOTAL_OUT_W-1:0] limit_ff, limit_in;
   logic [BURST_W-1:0]     burst_ff, burst_in;
   logic                   pend_ff, pend_in;

   // Working payload
   req_item_type           item_ff, item_in;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       pend_idx_ff, pend_idx_in;
   entry_type              best_ff, best_in;
   logic [CNT_W-1:0]       best_idx_ff, best_idx_in;
   logic                   evict_ff, evict_in;
   logic                   full_ff, full_in;

   // Memory port
   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   entry_type              ram_wr_data;
   logic                   ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   entry_type              ram_rd_data;

   // Helpers
   entry_type              new_entry;
   logic [CNT_W-1:0]       ptr_m1;
   logic [CNT_W-1:0]       ptr_p1;
   logic [EXT_W-1:0]       total_ext;
   logic [CEXT_W-1:0]      count_ext;
   logic                   total_gt_limit;
   logic                   more_evict;
   logic                   scan_issue;
   logic                   ins_done;

   cesm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign new_entry = '{id: item_ff.file_id, timestamp: item_ff.timestamp,
                        size: item_ff.size};
   assign ptr_m1    = ptr_ff - 1'b1;
   assign ptr_p1    = ptr_ff + 1'b1;
   assign total_ext = EXT_W'(total_ff);
   assign count_ext = CEXT_W'(held_count_ff);

   // Eviction continues while the burst has room, entries remain and the total is over the ceiling
   assign total_gt_limit = total_ext > EXT_W'(limit_ff);
   assign more_evict     = (burst_ff < BURST_W'(MAX_BURST)) && (held_count_ff != '0)
                           && total_gt_limit;
   assign scan_issue     = ptr_ff < held_count_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign res_valid = (state_ff == ST_EMIT);

   // Build the result from the updated total and count
   always_comb begin
      res_item                   = '0;
      res_item.evicted_valid     = evict_ff;
      res_item.evicted_id        = evict_ff ? best_ff.id        : '0;
      res_item.evicted_timestamp = evict_ff ? best_ff.timestamp : '0;
      res_item.evicted_size      = evict_ff ? best_ff.size      : '0;
      res_item.total_size        = (total_ext > EXT_W'(TOTAL_OUT_MAX)) ?
                                   TOTAL_OUT_MAX : total_ext[TOTAL_OUT_W-1:0];
      res_item.entry_count       = count_ext[ENTRY_CNT_W-1:0];
      res_item.full_error        = full_ff;
      res_item.last              = !(evict_ff && more_evict);
   end

   // Sequence inserts, scans and compaction over the entry memory
   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      total_in      = total_ff;
      limit_in      = limit_ff;
      burst_in      = burst_ff;
      pend_in       = 1'b0;
      item_in       = item_ff;
      ptr_in        = ptr_ff;
      pend_idx_in   = pend_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      evict_in      = evict_ff;
      full_in       = full_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ptr_ff[IDX_W-1:0];
      ram_wr_data   = new_entry;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ptr_ff[IDX_W-1:0];
      ins_done      = 1'b0;

      if (csr_valid) begin
         limit_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_item;
               if (req_item.operation == OP_OPTIMIZE) begin
                  burst_in = '0;
                  state_in = ST_OPT_START;
               end else if (held_count_ff >= CNT_W'(CAPACITY)) begin
                  full_in  = 1'b1;
                  evict_in = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  ptr_in   = held_count_ff;
                  state_in = ST_INS_RD;
               end
            end
         end
         // Walk down from the tail; place the item at the head when reached
         ST_INS_RD: begin
            if (ptr_ff == '0) begin
               ram_wr_en = 1'b1;
               ins_done  = 1'b1;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_m1[IDX_W-1:0];
               state_in    = ST_INS_WR;
            end
         end
         // Shift an entry up if it is not older than the item, else place the item
         ST_INS_WR: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data.timestamp >= item_ff.timestamp) begin
               ram_wr_data = ram_rd_data;
               ptr_in      = ptr_m1;
               state_in    = ST_INS_RD;
            end else begin
               ins_done = 1'b1;
            end
         end
         ST_OPT_START: begin
            if (more_evict) begin
               ptr_in   = '0;
               state_in = ST_SCAN;
            end else begin
               evict_in = 1'b0;
               full_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         // Stream reads over all entries; keep the first smallest
         ST_SCAN: begin
            ram_rd_en   = scan_issue;
            pend_in     = scan_issue;
            pend_idx_in = ptr_ff;
            if (scan_issue) begin
               ptr_in = ptr_p1;
            end
            if (pend_ff) begin
               if (pend_idx_ff == '0 || ram_rd_data.size < best_ff.size) begin
                  best_in     = ram_rd_data;
                  best_idx_in = pend_idx_ff;
               end
            end
            if (!scan_issue && !pend_ff) begin
               ptr_in   = best_idx_ff;
               state_in = ST_SH_RD;
            end
         end
         // Close the gap left by the evicted entry, reading and then writing each entry behind it
         ST_SH_RD: begin
            if (ptr_p1 < held_count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_p1[IDX_W-1:0];
               state_in    = ST_SH_WR;
            end else begin
               held_count_in = held_count_ff - 1'b1;
               total_in      = total_ff - TOT_W'(best_ff.size);
               burst_in      = burst_ff + 1'b1;
               evict_in      = 1'b1;
               full_in       = 1'b0;
               state_in      = ST_EMIT;
            end
         end
         ST_SH_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            ptr_in      = ptr_p1;
            state_in    = ST_SH_RD;
         end
         ST_EMIT: begin
            if (res_ready) begin
               state_in = (evict_ff && more_evict) ? ST_OPT_START : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Account for a placed item
      if (ins_done) begin
         held_count_in = held_count_ff + 1'b1;
         total_in      = total_ff + TOT_W'(item_ff.size);
         evict_in      = 1'b0;
         full_in       = 1'b0;
         state_in      = ST_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_count_ff <= '0;
         total_ff      <= '0;
         limit_ff      <= LIMIT_RESET;
         burst_ff      <= '0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         total_ff      <= total_in;
         limit_ff      <= limit_in;
         burst_ff      <= burst_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ptr_ff      <= ptr_in;
      pend_idx_ff <= pend_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      evict_ff    <= evict_in;
      full_ff     <= full_in;
   end

   // Count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // Burst never passes its limit
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      burst_ff <= BURST_W'(MAX_BURST))
      else $error("eviction burst beyond limit");

   // A finished eviction removes exactly one entry
   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SH_RD && state_in == ST_EMIT)
      |=> held_count_ff == $past(held_count_ff) - 1'b1)
      else $error("eviction did not drop one entry");

   // A dropped insert leaves the store untouched
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_item.operation == OP_INSERT
       && held_count_ff == CNT_W'(CAPACITY))
      |=> held_count_ff == $past(held_count_ff) && total_ff == $past(total_ff))
      else $error("full insert changed the store");

   // The memory is written only while inserting or compacting
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_INS_RD || state_ff == ST_INS_WR
                     || state_ff == ST_SH_WR))
      else $error("entry memory written outside insert or compaction");

endmodule

### tb/evict_store_checker.sv
`timescale 1ns / 100ps
// Checker for the capacity-bounded store: watches the req, rsp and csr channels,
// keeps its own copy of the entry list and compares every result item in order.
// Depends on cesm_pkg for the item types, widths and codes.
module evict_store_checker
   import cesm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_item_type           req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_item_type           rsp_item,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [TOTAL_OUT_W-1:0] csr_data,
   output int                     fail_count,
   output int                     outstanding
);

   localparam int DEPTH = CAPACITY_DEF;

   // Shadow store, kept in timestamp order
   entry_type              entries [DEPTH];
   int                     held_n;
   logic [31:0]            total_exact;
   logic [TOTAL_OUT_W-1:0] ceiling;
   rsp_item_type           expected_q [$];

   // Saturate the exact total to the reported width
   function automatic logic [TOTAL_OUT_W-1:0] reported_total();
      return (total_exact > TOTAL_OUT_MAX) ? TOTAL_OUT_MAX : total_exact[TOTAL_OUT_W-1:0];
   endfunction

   // Result item carrying the current total and count, all else zero
   function automatic rsp_item_type status_result();
      rsp_item_type r;
      r = '0;
      r.total_size  = reported_total();
      r.entry_count = ENTRY_CNT_W'(held_n);
      return r;
   endfunction

   // Apply one accepted item to the shadow store and queue its results
   function automatic void predict_item(input req_item_type it);
      rsp_item_type r;
      entry_type    gone;
      int           pos;
      int           best;
      int           evicted;
      if (it.operation == OP_INSERT) begin
         if (held_n >= DEPTH) begin
            // Full store: drop the entry, flag it
            r = status_result();
            r.full_error = 1'b1;
         end else begin
            // Place ahead of the first entry that is not older
            pos = 0;
            while (pos < held_n && entries[pos].timestamp < it.timestamp)
               pos++;
            for (int j = held_n; j > pos; j--)
               entries[j] = entries[j-1];
            entries[pos].id        = it.file_id;
            entries[pos].timestamp = it.timestamp;
            entries[pos].size      = it.size;
            held_n++;
            total_exact += it.size;
            r = status_result();
         end
         r.last = 1'b1;
         expected_q.push_back(r);
      end else begin
         // Evict the smallest, earliest on ties, until within the ceiling
         evicted = 0;
         while (evicted < MAX_BURST && held_n > 0 && total_exact > ceiling) begin
            best = 0;
            for (int j = 1; j < held_n; j++)
               if (entries[j].size < entries[best].size)
                  best = j;
            gone = entries[best];
            for (int j = best; j + 1 < held_n; j++)
               entries[j] = entries[j+1];
            held_n--;
            total_exact -= gone.size;
            r = status_result();
            r.evicted_valid     = 1'b1;
            r.evicted_id        = gone.id;
            r.evicted_timestamp = gone.timestamp;
            r.evicted_size      = gone.size;
            expected_q.push_back(r);
            evicted++;
         end
         if (evicted == 0) begin
            r = status_result();
            r.last = 1'b1;
            expected_q.push_back(r);
         end else begin
            expected_q[expected_q.size()-1].last = 1'b1;
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare one result item with the oldest expectation
   function automatic void check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_q.size() == 0) begin
         $error("result item with nothing expected: %h", got);
         fail_count++;
      end else begin
         want = expected_q.pop_front();
         check_field("evicted_valid", want.evicted_valid, got.evicted_valid);
         check_field("evicted_id", want.evicted_id, got.evicted_id);
         check_field("evicted_timestamp", want.evicted_timestamp, got.evicted_timestamp);
         check_field("evicted_size", want.evicted_size, got.evicted_size);
         check_field("total_size", want.total_size, got.total_size);
         check_field("entry_count", want.entry_count, got.entry_count);
         check_field("full_error", want.full_error, got.full_error);
         check_field("last", want.last, got.last);
      end
   endfunction

   // Sample all handshakes at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         held_n      = 0;
         total_exact = '0;
         ceiling     = LIMIT_RESET;
         expected_q.delete();
         fail_count  = 0;
      end else begin
         if (csr_valid && csr_ready)
            ceiling = csr_data;
         if (req_valid && req_ready)
            predict_item(req_item);
         if (rsp_valid && rsp_ready)
            check_result(rsp_item);
      end
      outstanding = expected_q.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for capacity_evict_smallest_store_top: clock, reset,
// stimulus on the req and csr channels, receiver stalls and the verdict.
// Depends on cesm_pkg, the block and evict_store_checker.
module testbench;
   import cesm_pkg::*;

   localparam int PHASE_ITEMS    = 48;
   localparam int NUM_PHASES     = 6;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_item_type           req_item;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_item_type           rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [TOTAL_OUT_W-1:0] csr_data;

   int fail_count;
   int outstanding;
   int quiet_cycles;
   int rsp_hold_len;
   bit calm;

   capacity_evict_smallest_store_top #(.CAPACITY(CAPACITY_DEF)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   evict_store_checker store_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic req_item_type insert_item(input logic [ID_W-1:0] id,
                                                input logic [TS_W-1:0] ts,
                                                input logic [SIZE_W-1:0] sz);
      req_item_type it;
      it.operation = OP_INSERT;
      it.file_id   = id;
      it.timestamp = ts;
      it.size      = sz;
      return it;
   endfunction

   // Optimize item; the other fields carry noise
   function automatic req_item_type optimize_item();
      req_item_type it;
      it = insert_item(ID_W'($urandom), $urandom, SIZE_W'($urandom));
      it.operation = OP_OPTIMIZE;
      return it;
   endfunction

   // Random item: timestamps from pools so that ties are common
   function automatic req_item_type make_item(input int opt_pct);
      logic [TS_W-1:0]   ts;
      logic [SIZE_W-1:0] sz;
      if ($urandom_range(0, 99) < opt_pct)
         return optimize_item();
      case ($urandom_range(0, 3))
         0: ts = $urandom;
         1: ts = $urandom_range(0, 7);
         2: ts = $urandom_range(0, 1) ? '1 : '0;
         default: ts = 32'h8000_0000 + $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 3))
         0: sz = SIZE_W'($urandom);
         1: sz = SIZE_W'($urandom_range(0, 4095));
         2: sz = $urandom_range(0, 1) ? '1 : '0;
         default: sz = SIZE_W'($urandom_range(30000, 65535));
      endcase
      return insert_item(ID_W'($urandom), ts, sz);
   endfunction

   // Offer one item after a random gap; return at the falling edge after acceptance
   task automatic send_req(input req_item_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected result item has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic write_limit(input logic [TOTAL_OUT_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stall per result item, one long hold on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            stall = rsp_hold_len;
            rsp_hold_len = 0;
         end else begin
            stall = draw_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // End the run when nothing has been accepted for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      logic [TOTAL_OUT_W-1:0] lim;
      int                     opt_pct;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_item     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      rsp_hold_len = 0;
      calm         = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Optimize on an empty store
      send_req(optimize_item());
      // Extremes of the fields; an equal timestamp at the head goes first
      send_req(insert_item(8'h00, 32'h0000_0000, 16'h0000));
      send_req(insert_item(8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
      send_req(insert_item(8'h01, 32'h0000_0000, 16'h0000));
      send_req(insert_item(8'h02, 32'h8000_0000, 16'hFFFF));
      send_req(insert_item(8'h03, 32'h8000_0000, 16'h0001));
      // Evictions with ties in size, down to an empty store
      send_req(optimize_item());

      // Fill the store, overflow it, then evict a full burst
      write_limit('0);
      for (int i = 0; i < CAPACITY_DEF; i++)
         send_req(insert_item(ID_W'(i), $urandom_range(0, 5), SIZE_W'($urandom)));
      send_req(insert_item(8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
      send_req(optimize_item());
      send_req(optimize_item());

      // Random phases, each under its own ceiling
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: lim = TOTAL_OUT_MAX;
            1: lim = '0;
            2: lim = LIMIT_RESET;
            3: lim = TOTAL_OUT_W'($urandom_range(0, TOTAL_OUT_MAX));
            4: lim = TOTAL_OUT_W'($urandom_range(100000, 400000));
            default: lim = TOTAL_OUT_W'($urandom_range(0, 70000));
         endcase
         write_limit(lim);
         calm    = (p == 2);
         opt_pct = (p == 0) ? 10 : $urandom_range(15, 40);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Stall the receiver long enough to back up the input
            if (p == 3 && i == 8)
               rsp_hold_len = LONG_HOLD;
            // Pause the sender until the output side is empty
            if (p == 1 && i == PHASE_ITEMS / 2)
               wait_drained();
            send_req(make_item(opt_pct));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
